// File: rtl/rotate_vector_axis_angle_macros.svh
// Assertion helpers for the axis-angle rotation block.
`ifndef ROTATE_VECTOR_AXIS_ANGLE_MACROS_SVH
`define ROTATE_VECTOR_AXIS_ANGLE_MACROS_SVH

// The consequent must hold whenever the antecedent holds.
`define RVA_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The condition must never hold outside reset.
`define RVA_ASSERT_NEVER(name, clk, rst_n, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// File: rtl/rva_pkg.sv
package rva_pkg;

    localparam int WORD_WIDTH   = 32;
    localparam int FRAC_BITS    = 16;
    localparam int COEF_BITS    = 30;
    localparam int NORM_BITS    = WORD_WIDTH - 1;
    localparam int SQRT_STEPS   = 32;
    localparam int DIV_STEPS    = COEF_BITS + 1;
    localparam int PRESHIFT_MAX = 30;
    localparam int DBL_STEPS    = 15;
    localparam int CORDIC_STEPS = 31;
    localparam int ANG_W        = 34;

    // Angle exponent offset: k = bit_length + K_OFFSET.
    localparam int K_OFFSET = 60 - NORM_BITS - FRAC_BITS;

    // Index of the valid bit that belongs to a given pipeline register.
    localparam int ST_SQRT_END   = 5 + SQRT_STEPS;
    localparam int ST_CORDIC_END = ST_SQRT_END + DBL_STEPS + 2 + CORDIC_STEPS;
    localparam int LATENCY       = ST_CORDIC_END + 8;

    localparam logic [63:0] PI_Q61      = 64'h6487ED5110B4611A;
    localparam logic [63:0] PI_Q61_HALF = PI_Q61 >> 1;

    localparam logic signed [ANG_W-1:0] CORDIC_GAIN_Q30 = 34'sh26DD3B6A;

    localparam logic [WORD_WIDTH-1:0] WORD_MAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
    localparam logic [WORD_WIDTH-1:0] WORD_MIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};

    localparam logic [31:0] ATAN_Q30 [CORDIC_STEPS] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
        32'h00000001
    };

    typedef struct packed {
        logic signed [WORD_WIDTH-1:0] point_x;
        logic signed [WORD_WIDTH-1:0] point_y;
        logic signed [WORD_WIDTH-1:0] point_z;
        logic signed [WORD_WIDTH-1:0] rot_x;
        logic signed [WORD_WIDTH-1:0] rot_y;
        logic signed [WORD_WIDTH-1:0] rot_z;
    } t_req;

    typedef struct packed {
        logic signed [WORD_WIDTH-1:0] out_x;
        logic signed [WORD_WIDTH-1:0] out_y;
        logic signed [WORD_WIDTH-1:0] out_z;
        logic                         saturated;
    } t_res;

endpackage

// File: rtl/rotate_vector_axis_angle.sv
// Axis-angle rotation of a 3-D point in signed Q16.16 fixed point.
// A request carries the point and the rotation vector, whose direction is the
// axis and whose length is the angle in radians. A request is taken at every
// rising clock edge at which start is high and busy is low. Busy is low at all
// times except while reset is held, so a new request may enter in every cycle.
// The rotated point appears on o_res for exactly one cycle, marked by o_done;
// results leave in request order. Throughput is one request per cycle. The
// latency is set by the chain of one-bit-per-stage units: a 32-stage square
// root for the axis length, the modular reduction of the half angle, and a
// 31-stage CORDIC that runs side by side with three 31-stage dividers which
// form the unit axis.
// A zero rotation vector returns the point unchanged. Components that do not
// fit the word are clipped, and o_res.saturated is then set.
// The receiver cannot hold results off: o_done is a strobe and the result is
// gone after that cycle. Synchronous reset (i_rst_n low) empties the pipeline;
// requests in flight are dropped and no result is produced for them.
`include "rotate_vector_axis_angle_macros.svh"

module rotate_vector_axis_angle (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  rva_pkg::t_req i_req,
    output logic          o_done,
    output rva_pkg::t_res o_res
);
    import rva_pkg::*;

    // Point, axis signs and the zero-rotation flag travel with every stage.
    typedef struct packed {
        logic [2:0][WORD_WIDTH-1:0] p;
        logic [2:0]                 neg;
        logic                       zero;
    } t_carry;

    typedef struct packed {
        t_carry                     c;
        logic [2:0][WORD_WIDTH-1:0] mag;
    } t_s1;

    typedef struct packed {
        t_carry                     c;
        logic [2:0][WORD_WIDTH-1:0] mag;
        logic [5:0]                 nbits;
    } t_s2;

    typedef struct packed {
        t_carry                    c;
        logic [2:0][NORM_BITS-1:0] mag;
        logic [5:0]                k;
    } t_s3;

    typedef struct packed {
        t_carry                      c;
        logic [2:0][NORM_BITS-1:0]   mag;
        logic [5:0]                  k;
        logic [2:0][2*NORM_BITS-1:0] sq;
    } t_s4;

    typedef struct packed {
        t_carry                    c;
        logic [2:0][NORM_BITS-1:0] mag;
        logic [5:0]                k;
        logic [63:0]               rem;
        logic [63:0]               root;
    } t_sq;

    typedef struct packed {
        t_carry                    c;
        logic [2:0][NORM_BITS-1:0] mag;
        logic [5:0]                k;
        logic [31:0]               len;
        logic [63:0]               r;
    } t_db;

    typedef struct packed {
        t_carry                    c;
        logic [31:0]               len;
        logic [2:0][31:0]          rem;
        logic [2:0][DIV_STEPS-1:0] nlo;
        logic [2:0][DIV_STEPS-1:0] q;
        logic signed [ANG_W-1:0]   x;
        logic signed [ANG_W-1:0]   y;
        logic signed [ANG_W-1:0]   z;
    } t_cd;

    typedef struct packed {
        t_carry                  c;
        logic signed [ANG_W-1:0] x;
        logic [2:0][ANG_W-1:0]   v;
    } t_v;

    typedef struct packed {
        t_carry              c;
        logic signed [67:0]  xx;
        logic [2:0][67:0]    vv;
        logic [2:0][67:0]    vx;
        logic [2:0][67:0]    vc;
    } t_m1;

    typedef struct packed {
        t_carry              c;
        logic signed [67:0]  w;
        logic [2:0][67:0]    vv;
        logic [2:0][67:0]    vx;
        logic [2:0][67:0]    vc;
    } t_m2;

    typedef struct packed {
        t_carry           c;
        logic [8:0][35:0] m;
    } t_m3;

    typedef struct packed {
        t_carry           c;
        logic [8:0][67:0] mp;
    } t_r1;

    typedef struct packed {
        t_carry           c;
        logic [2:0][39:0] o;
    } t_r2;

    // Round a Q60 matrix entry to Q2.30.
    function automatic logic signed [35:0] round_entry(input logic signed [69:0] e);
        logic signed [69:0] t;
        t = e + (70'sd1 <<< (COEF_BITS - 1));
        return 36'(t >>> COEF_BITS);
    endfunction

    logic [LATENCY-1:0] r_vld;
    t_req               r_s0;
    t_s1                r_s1, n_s1;
    t_s2                r_s2, n_s2;
    t_s3                r_s3, n_s3;
    t_s4                r_s4, n_s4;
    t_sq                r_sq [0:SQRT_STEPS];
    t_sq                n_sq0;
    t_db                r_db [0:DBL_STEPS];
    t_db                n_db0;
    t_cd                r_cd [0:CORDIC_STEPS];
    t_cd                n_cd0;
    t_v                 r_v, n_v;
    t_m1                r_m1, n_m1;
    t_m2                r_m2, n_m2;
    t_m3                r_m3, n_m3;
    t_r1                r_r1, n_r1;
    t_r2                r_r2, n_r2;
    t_res               r_out, n_out;

    // No request is taken while reset is held; otherwise one per cycle.
    assign busy   = ~i_rst_n;
    assign o_done = r_vld[LATENCY-1];
    assign o_res  = r_out;

    // The valid bits form one shift line beside the data stages. Nothing
    // downstream can stall, so every stage advances in every cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LATENCY-2:0], start & ~busy};
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0 <= i_req;
    end

    // Stage 1: magnitudes and signs of the rotation vector.
    always_comb begin
        logic [2:0][WORD_WIDTH-1:0] rot;
        rot[0] = r_s0.rot_x;
        rot[1] = r_s0.rot_y;
        rot[2] = r_s0.rot_z;
        n_s1.c.p[0] = r_s0.point_x;
        n_s1.c.p[1] = r_s0.point_y;
        n_s1.c.p[2] = r_s0.point_z;
        n_s1.c.zero = 1'b0;
        for (int c = 0; c < 3; c++) begin
            n_s1.c.neg[c] = rot[c][WORD_WIDTH-1];
            n_s1.mag[c]   = rot[c][WORD_WIDTH-1] ? (~rot[c] + 1'b1) : rot[c];
        end
    end

    // Stage 2: largest magnitude and its bit length.
    always_comb begin
        logic [WORD_WIDTH-1:0] mmax;
        mmax = (r_s1.mag[0] > r_s1.mag[1]) ? r_s1.mag[0] : r_s1.mag[1];
        if (r_s1.mag[2] > mmax) begin
            mmax = r_s1.mag[2];
        end
        n_s2.c      = r_s1.c;
        n_s2.c.zero = (mmax == '0);
        n_s2.mag    = r_s1.mag;
        n_s2.nbits  = '0;
        for (int b = 0; b < WORD_WIDTH; b++) begin
            if (mmax[b]) begin
                n_s2.nbits = 6'(b + 1);
            end
        end
    end

    // Stage 3: scale all components so the largest has exactly 31 bits.
    always_comb begin
        logic [5:0] sh_l;
        sh_l     = 6'(NORM_BITS) - r_s2.nbits;
        n_s3.c   = r_s2.c;
        n_s3.k   = r_s2.nbits + 6'(K_OFFSET);
        for (int c = 0; c < 3; c++) begin
            if (r_s2.nbits == 6'(WORD_WIDTH)) begin
                n_s3.mag[c] = r_s2.mag[c][WORD_WIDTH-1:1];
            end else begin
                n_s3.mag[c] = NORM_BITS'(r_s2.mag[c] << sh_l);
            end
        end
    end

    // Stage 4: squares.
    always_comb begin
        n_s4.c   = r_s3.c;
        n_s4.mag = r_s3.mag;
        n_s4.k   = r_s3.k;
        for (int c = 0; c < 3; c++) begin
            n_s4.sq[c] = r_s3.mag[c] * r_s3.mag[c];
        end
    end

    // Stage 5: sum of squares, loaded into the square root pipeline.
    always_comb begin
        n_sq0.c    = r_s4.c;
        n_sq0.mag  = r_s4.mag;
        n_sq0.k    = r_s4.k;
        n_sq0.rem  = 64'(r_s4.sq[0]) + 64'(r_s4.sq[1]) + 64'(r_s4.sq[2]);
        n_sq0.root = '0;
    end

    always_ff @(posedge i_clk) begin
        r_s1     <= n_s1;
        r_s2     <= n_s2;
        r_s3     <= n_s3;
        r_s4     <= n_s4;
        r_sq[0]  <= n_sq0;
    end

    // Square root, one result bit per stage.
    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
        localparam logic [63:0] SQ_BIT = 64'd1 << (2 * (SQRT_STEPS - 1 - j));
        t_sq         n_sq;
        logic [63:0] trial;

        always_comb begin
            n_sq  = r_sq[j];
            trial = r_sq[j].root + SQ_BIT;
            if (r_sq[j].rem >= trial) begin
                n_sq.rem  = r_sq[j].rem - trial;
                n_sq.root = (r_sq[j].root >> 1) + SQ_BIT;
            end else begin
                n_sq.root = r_sq[j].root >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            r_sq[j+1] <= n_sq;
        end
    end

    // Half angle in Q.61: the length is shifted up without reduction as far
    // as it safely stays below pi, then the rest is modular doubling.
    always_comb begin
        logic [5:0] pre;
        pre       = (r_sq[SQRT_STEPS].k > 6'(PRESHIFT_MAX)) ? 6'(PRESHIFT_MAX)
                                                            : r_sq[SQRT_STEPS].k;
        n_db0.c   = r_sq[SQRT_STEPS].c;
        n_db0.mag = r_sq[SQRT_STEPS].mag;
        n_db0.k   = r_sq[SQRT_STEPS].k;
        n_db0.len = r_sq[SQRT_STEPS].root[31:0];
        n_db0.r   = 64'(r_sq[SQRT_STEPS].root[31:0]) << pre;
    end

    always_ff @(posedge i_clk) begin
        r_db[0] <= n_db0;
    end

    for (genvar j = 0; j < DBL_STEPS; j++) begin : g_dbl
        t_db         n_db;
        logic [63:0] dbl;

        always_comb begin
            n_db = r_db[j];
            dbl  = {r_db[j].r[62:0], 1'b0};
            if (dbl >= PI_Q61) begin
                dbl = dbl - PI_Q61;
            end
            if (r_db[j].k > 6'(PRESHIFT_MAX + j)) begin
                n_db.r = dbl;
            end
        end

        always_ff @(posedge i_clk) begin
            r_db[j+1] <= n_db;
        end
    end

    // Fold the angle into (-pi/2, pi/2], round to Q2.30, and set up the
    // dividers that form the unit axis.
    always_comb begin
        logic signed [65:0] rs;
        logic signed [65:0] zr;
        logic [61:0]        num;
        if (r_db[DBL_STEPS].r > PI_Q61_HALF) begin
            rs = $signed({2'b00, r_db[DBL_STEPS].r}) - $signed({2'b00, PI_Q61});
        end else begin
            rs = $signed({2'b00, r_db[DBL_STEPS].r});
        end
        zr        = (rs + (66'sd1 <<< 30)) >>> 31;
        n_cd0.c   = r_db[DBL_STEPS].c;
        n_cd0.len = r_db[DBL_STEPS].len;
        n_cd0.x   = CORDIC_GAIN_Q30;
        n_cd0.y   = '0;
        n_cd0.z   = zr[ANG_W-1:0];
        for (int c = 0; c < 3; c++) begin
            num = (62'(r_db[DBL_STEPS].mag[c]) << COEF_BITS)
                + 62'(r_db[DBL_STEPS].len >> 1);
            n_cd0.rem[c] = {1'b0, num[61:DIV_STEPS]};
            n_cd0.nlo[c] = num[DIV_STEPS-1:0];
            n_cd0.q[c]   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cd[0] <= n_cd0;
    end

    // CORDIC rotation and the three restoring dividers advance together.
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
        t_cd                     n_cd;
        logic signed [ANG_W-1:0] dx;
        logic signed [ANG_W-1:0] dy;
        logic signed [ANG_W-1:0] ang;

        always_comb begin
            logic [32:0] t;
            logic        ge;
            n_cd = r_cd[i];
            dx   = $signed(r_cd[i].y) >>> i;
            dy   = $signed(r_cd[i].x) >>> i;
            ang  = $signed({2'b00, ATAN_Q30[i]});
            if (!r_cd[i].z[ANG_W-1]) begin
                n_cd.x = r_cd[i].x - dx;
                n_cd.y = r_cd[i].y + dy;
                n_cd.z = r_cd[i].z - ang;
            end else begin
                n_cd.x = r_cd[i].x + dx;
                n_cd.y = r_cd[i].y - dy;
                n_cd.z = r_cd[i].z + ang;
            end
            for (int c = 0; c < 3; c++) begin
                t  = {r_cd[i].rem[c], r_cd[i].nlo[c][DIV_STEPS-1]};
                ge = (t >= {1'b0, r_cd[i].len});
                n_cd.rem[c] = ge ? 32'(t - {1'b0, r_cd[i].len}) : t[31:0];
                n_cd.nlo[c] = {r_cd[i].nlo[c][DIV_STEPS-2:0], 1'b0};
                n_cd.q[c]   = {r_cd[i].q[c][DIV_STEPS-2:0], ge};
            end
        end

        always_ff @(posedge i_clk) begin
            r_cd[i+1] <= n_cd;
        end
    end

    // Vector part of the quaternion: v = u * sin, rounded to Q2.30.
    always_comb begin
        logic signed [31:0] uq;
        logic signed [31:0] u;
        logic signed [65:0] prod;
        logic signed [65:0] rv;
        n_v.c = r_cd[CORDIC_STEPS].c;
        n_v.x = r_cd[CORDIC_STEPS].x;
        for (int c = 0; c < 3; c++) begin
            uq       = $signed({1'b0, r_cd[CORDIC_STEPS].q[c]});
            u        = r_cd[CORDIC_STEPS].c.neg[c] ? -uq : uq;
            prod     = u * r_cd[CORDIC_STEPS].y;
            rv       = (prod + (66'sd1 <<< (COEF_BITS - 1))) >>> COEF_BITS;
            n_v.v[c] = rv[ANG_W-1:0];
        end
    end

    // Products of the scalar and vector parts.
    always_comb begin
        logic signed [67:0] t;
        n_m1.c  = r_v.c;
        n_m1.xx = r_v.x * r_v.x;
        for (int c = 0; c < 3; c++) begin
            t           = $signed(r_v.v[c]) * $signed(r_v.v[c]);
            n_m1.vv[c]  = t;
            t           = $signed(r_v.v[c]) * r_v.x;
            n_m1.vx[c]  = t;
        end
        t          = $signed(r_v.v[0]) * $signed(r_v.v[1]);
        n_m1.vc[0] = t;
        t          = $signed(r_v.v[0]) * $signed(r_v.v[2]);
        n_m1.vc[1] = t;
        t          = $signed(r_v.v[1]) * $signed(r_v.v[2]);
        n_m1.vc[2] = t;
    end

    // Common diagonal term w = s^2 - v.v.
    always_comb begin
        n_m2.c  = r_m1.c;
        n_m2.vv = r_m1.vv;
        n_m2.vx = r_m1.vx;
        n_m2.vc = r_m1.vc;
        n_m2.w  = r_m1.xx - ($signed(r_m1.vv[0]) + $signed(r_m1.vv[1])
                           + $signed(r_m1.vv[2]));
    end

    // Rotation matrix entries, rounded to Q2.30.
    always_comb begin
        logic signed [69:0] w;
        logic signed [69:0] vv0, vv1, vv2, vx0, vx1, vx2, v01, v02, v12;
        w   = 70'(r_m2.w);
        vv0 = 70'($signed(r_m2.vv[0])) <<< 1;
        vv1 = 70'($signed(r_m2.vv[1])) <<< 1;
        vv2 = 70'($signed(r_m2.vv[2])) <<< 1;
        vx0 = 70'($signed(r_m2.vx[0])) <<< 1;
        vx1 = 70'($signed(r_m2.vx[1])) <<< 1;
        vx2 = 70'($signed(r_m2.vx[2])) <<< 1;
        v01 = 70'($signed(r_m2.vc[0])) <<< 1;
        v02 = 70'($signed(r_m2.vc[1])) <<< 1;
        v12 = 70'($signed(r_m2.vc[2])) <<< 1;
        n_m3.c    = r_m2.c;
        n_m3.m[0] = round_entry(w + vv0);
        n_m3.m[1] = round_entry(v01 - vx2);
        n_m3.m[2] = round_entry(v02 + vx1);
        n_m3.m[3] = round_entry(v01 + vx2);
        n_m3.m[4] = round_entry(w + vv1);
        n_m3.m[5] = round_entry(v12 - vx0);
        n_m3.m[6] = round_entry(v02 - vx1);
        n_m3.m[7] = round_entry(v12 + vx0);
        n_m3.m[8] = round_entry(w + vv2);
    end

    // Matrix times point: nine products.
    always_comb begin
        logic signed [67:0] t;
        n_r1.c = r_m3.c;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                t = $signed(r_m3.m[3*r+c]) * $signed(r_m3.c.p[c]);
                n_r1.mp[3*r+c] = t;
            end
        end
    end

    // Row sums, rounded back to the point format.
    always_comb begin
        logic signed [69:0] s;
        n_r2.c = r_r1.c;
        for (int r = 0; r < 3; r++) begin
            s = 70'($signed(r_r1.mp[3*r])) + 70'($signed(r_r1.mp[3*r+1]))
              + 70'($signed(r_r1.mp[3*r+2])) + (70'sd1 <<< (COEF_BITS - 1));
            s = s >>> COEF_BITS;
            n_r2.o[r] = s[39:0];
        end
    end

    // Clip to the word, or pass the point through for a zero rotation.
    always_comb begin
        logic [2:0][WORD_WIDTH-1:0] res;
        logic                       sat;
        sat = 1'b0;
        for (int r = 0; r < 3; r++) begin
            if (r_r2.c.zero) begin
                res[r] = r_r2.c.p[r];
            end else if (r_r2.o[r][39:WORD_WIDTH-1] == '0
                      || r_r2.o[r][39:WORD_WIDTH-1] == '1) begin
                res[r] = r_r2.o[r][WORD_WIDTH-1:0];
            end else begin
                res[r] = r_r2.o[r][39] ? WORD_MIN : WORD_MAX;
                sat    = 1'b1;
            end
        end
        n_out.out_x     = res[0];
        n_out.out_y     = res[1];
        n_out.out_z     = res[2];
        n_out.saturated = sat;
    end

    always_ff @(posedge i_clk) begin
        r_v   <= n_v;
        r_m1  <= n_m1;
        r_m2  <= n_m2;
        r_m3  <= n_m3;
        r_r1  <= n_r1;
        r_r2  <= n_r2;
        r_out <= n_out;
    end

    // The normalized axis length always has exactly 31 or 32 significant bits.
    `RVA_ASSERT_IMPL(a_len_normalized, i_clk, i_rst_n, r_vld[ST_SQRT_END] && !r_sq[SQRT_STEPS].c.zero, r_sq[SQRT_STEPS].root[63:32] == 32'd0 && r_sq[SQRT_STEPS].root[31:30] != 2'd0, "axis length out of normalized range")

    // Every divider remainder ends below the divisor.
    `RVA_ASSERT_IMPL(a_div_rem_bound, i_clk, i_rst_n, r_vld[ST_CORDIC_END] && !r_cd[CORDIC_STEPS].c.zero, r_cd[CORDIC_STEPS].rem[0] < r_cd[CORDIC_STEPS].len && r_cd[CORDIC_STEPS].rem[1] < r_cd[CORDIC_STEPS].len && r_cd[CORDIC_STEPS].rem[2] < r_cd[CORDIC_STEPS].len, "divider remainder not below divisor")

    // A unit axis component never exceeds one.
    `RVA_ASSERT_NEVER(a_unit_axis_bound, i_clk, i_rst_n, r_vld[ST_CORDIC_END] && !r_cd[CORDIC_STEPS].c.zero && (r_cd[CORDIC_STEPS].q[0] > 31'h40000000 || r_cd[CORDIC_STEPS].q[1] > 31'h40000000 || r_cd[CORDIC_STEPS].q[2] > 31'h40000000), "unit axis component above one")

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps

// Self-checking bench for the axis-angle rotation unit.
// An initial block fills a queue of pending requests: first a directed set,
// then 400 random ones. A clocked driver presents them on the falling
// edge, with idle gaps whose style changes every few dozen requests. A
// clocked monitor on the rising edge sees each request that is taken, runs the
// bit-exact rotation predictor on it and queues the expected result. Each
// o_done strobe is then checked field by field against the oldest expected
// result.
module tb_top;

    import rva_pkg::*;

    localparam int  CLK_HALF   = 2;
    localparam int  RST_CYCLES = 7;
    localparam int  IDLE_LIMIT = 4000;
    localparam int  N_RANDOM   = 400;

    // One pending request. When hold_until_drained is set, the driver waits
    // until every expected result has come back before it issues the request.
    typedef struct {
        t_req req;
        bit   hold_until_drained;
    } t_pending;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_req i_req = '0;
    logic o_done;
    t_res o_res;

    t_pending pending_reqs[$];
    t_res     expected_rot[$];

    int  error_count = 0;
    int  idle_cycles = 0;
    int  gap_left = 0;
    int  gap_style = 0;
    int  issued = 0;
    bit  req_taken = 1'b0;
    bit  stimulus_done = 1'b0;

    rotate_vector_axis_angle uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_done  (o_done),
        .o_res   (o_res)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Round a Q60 product to Q2.30, halves rounding up.
    function automatic longint round_q60(longint e);
        return (e + 64'sd536870912) >>> 30;
    endfunction

    // Bit-exact prediction of one rotated point.
    function automatic t_res rotate_point(t_req rq);
        longint            pnt[3];
        longint            axv[3];
        longint            unitv[3];
        longint            vq[3];
        longint            mtx[9];
        longint unsigned   mag[3];
        longint unsigned   mmax, sumsq, len, rem, bitv, num, root;
        longint            cx, cy, cz, dx, dy, rs, wv;
        int                nbits, shamt, kdbl;
        logic signed [127:0] acc, mm, pp;
        t_res              res;

        pnt[0] = rq.point_x;
        pnt[1] = rq.point_y;
        pnt[2] = rq.point_z;
        axv[0] = rq.rot_x;
        axv[1] = rq.rot_y;
        axv[2] = rq.rot_z;
        mmax = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = axv[i] < 0 ? longint'(-axv[i]) : axv[i];
            if (mag[i] > mmax)
                mmax = mag[i];
        end
        res.saturated = 1'b0;
        if (mmax == 0) begin
            res.out_x = rq.point_x;
            res.out_y = rq.point_y;
            res.out_z = rq.point_z;
            return res;
        end

        // Normalize the axis so the largest magnitude has 31 bits.
        nbits = 0;
        while (nbits < 64 && (mmax >> nbits) != 0)
            nbits++;
        shamt = nbits - 31;
        sumsq = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = shamt > 0 ? mag[i] >> shamt : mag[i] << (-shamt);
            sumsq += mag[i] * mag[i];
        end

        // Integer square root, one result bit per pass.
        num = sumsq;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > num)
            bitv >>= 2;
        while (bitv != 0) begin
            if (num >= root + bitv) begin
                num -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        len = root;
        for (int i = 0; i < 3; i++) begin
            unitv[i] = ((mag[i] << COEF_BITS) + len / 2) / len;
            if (axv[i] < 0)
                unitv[i] = -unitv[i];
        end

        // Half angle reduced modulo pi in Q.61, then folded to (-pi/2, pi/2].
        kdbl = shamt - FRAC_BITS + 60;
        rem = len % PI_Q61;
        if (kdbl >= 0) begin
            for (int i = 0; i < kdbl; i++) begin
                rem <<= 1;
                if (rem >= PI_Q61)
                    rem -= PI_Q61;
            end
        end else begin
            rem >>= (-kdbl > 63 ? 63 : -kdbl);
        end
        rs = rem;
        if (rem > PI_Q61 / 2)
            rs -= longint'(PI_Q61);
        cz = (rs + 64'sd1073741824) >>> 31;

        // Rotation-mode CORDIC gives cos in cx and sin in cy.
        cx = CORDIC_GAIN_Q30;
        cy = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cz >= 0) begin
                cx -= dx;
                cy += dy;
                cz -= longint'(ATAN_Q30[i]);
            end else begin
                cx += dx;
                cy -= dy;
                cz += longint'(ATAN_Q30[i]);
            end
        end

        for (int i = 0; i < 3; i++)
            vq[i] = round_q60(unitv[i] * cy);
        wv = cx * cx - (vq[0] * vq[0] + vq[1] * vq[1] + vq[2] * vq[2]);
        mtx[0] = round_q60(wv + 2 * vq[0] * vq[0]);
        mtx[1] = round_q60(2 * vq[0] * vq[1] - 2 * cx * vq[2]);
        mtx[2] = round_q60(2 * vq[0] * vq[2] + 2 * cx * vq[1]);
        mtx[3] = round_q60(2 * vq[0] * vq[1] + 2 * cx * vq[2]);
        mtx[4] = round_q60(wv + 2 * vq[1] * vq[1]);
        mtx[5] = round_q60(2 * vq[1] * vq[2] - 2 * cx * vq[0]);
        mtx[6] = round_q60(2 * vq[0] * vq[2] - 2 * cx * vq[1]);
        mtx[7] = round_q60(2 * vq[1] * vq[2] + 2 * cx * vq[0]);
        mtx[8] = round_q60(wv + 2 * vq[2] * vq[2]);

        // Each output row is summed at full width, rounded and clipped.
        for (int i = 0; i < 3; i++) begin
            acc = 0;
            for (int j = 0; j < 3; j++) begin
                mm = mtx[3 * i + j];
                pp = pnt[j];
                acc += mm * pp;
            end
            acc = (acc + 128'sd536870912) >>> 30;
            if (acc > 128'sd2147483647) begin
                acc = 128'sd2147483647;
                res.saturated = 1'b1;
            end
            if (acc < -128'sd2147483648) begin
                acc = -128'sd2147483648;
                res.saturated = 1'b1;
            end
            case (i)
                0: res.out_x = acc[WORD_WIDTH-1:0];
                1: res.out_y = acc[WORD_WIDTH-1:0];
                default: res.out_z = acc[WORD_WIDTH-1:0];
            endcase
        end
        return res;
    endfunction

    function automatic logic [31:0] rand_word();
        return $urandom();
    endfunction

    // A random angle component: mostly within six radians of zero, sometimes tiny,
    // sometimes zero, sometimes anywhere in the word.
    function automatic logic [31:0] rand_rot();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            return $signed($urandom_range(0, 32'h000C_0000)) - 32'sh0006_0000;
        else if (pick < 7)
            return $signed($urandom_range(0, 64)) - 32;
        else if (pick < 8)
            return '0;
        return rand_word();
    endfunction

    // A random point component: mostly moderate so few results clip.
    function automatic logic [31:0] rand_point();
        if ($urandom_range(0, 2) != 0)
            return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
        return rand_word();
    endfunction

    task automatic add_req(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                           logic [31:0] rx, logic [31:0] ry, logic [31:0] rz,
                           bit drain);
        t_pending item;
        item.req.point_x = px;
        item.req.point_y = py;
        item.req.point_z = pz;
        item.req.rot_x = rx;
        item.req.rot_y = ry;
        item.req.rot_z = rz;
        item.hold_until_drained = drain;
        pending_reqs.push_back(item);
    endtask

    // Stimulus, then the end-of-test wait and verdict.
    initial begin
        logic [31:0] one;
        logic [31:0] pi_q16;
        one = 32'h0001_0000;
        pi_q16 = 32'h0003_243F;

        // Zero rotation passes the point through, including the extremes.
        add_req(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 0, 0, 0, 0);
        add_req(32'hFFFF_FFFF, 32'h0000_0001, 32'h1234_5678, 0, 0, 0, 0);
        // Quarter and half turns about coordinate axes, then a turn about the diagonal.
        add_req(one, 0, 0, 0, 0, pi_q16 >> 1, 0);
        add_req(0, one, 0, pi_q16, 0, 0, 0);
        add_req(0, 0, one, 0, -pi_q16, 0, 0);
        add_req(one, one, one, pi_q16 >> 1, pi_q16 >> 1, pi_q16 >> 1, 0);
        // Smallest nonzero rotation vectors.
        add_req(32'h0100_0000, 32'h0200_0000, 32'h0300_0000, 1, 0, 0, 0);
        add_req(32'h0100_0000, 32'h0200_0000, 32'h0300_0000, 0, 0, 32'hFFFF_FFFF, 0);
        // Huge rotation vectors, where the axis loses low bits.
        add_req(one, one, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
        add_req(one, 0, one, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 0);
        add_req(one, 2 * one, 3 * one, 32'h8000_0000, 0, 0, 0);
        add_req(one, 2 * one, 3 * one, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
        // Out-of-range results clip high and low.
        add_req(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, pi_q16 >> 2, 0);
        add_req(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, pi_q16 >> 2, 0, 0, 0);
        add_req(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, pi_q16 >> 2, 0, 0);
        // Angles past a full turn and with mixed signs.
        add_req(one, -one, 0, 32'h0064_0000, 32'hFF9C_0000, 32'h0032_0000, 0);
        add_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);

        for (int i = 0; i < N_RANDOM; i++) begin
            // A handful of requests wait for the pipeline to empty first.
            add_req(rand_point(), rand_point(), rand_point(),
                    rand_rot(), rand_rot(), rand_rot(),
                    (i % 97) == 50);
        end

        wait (stimulus_done && expected_rot.size() == 0);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Reset is held from time zero and released on a falling edge.
    initial begin
        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Driver: a request stays on the bus until it is taken. Between requests
    // it may idle; the gap style is redrawn every 40 requests so that long
    // back-to-back stretches alternate with sparse and bursty ones.
    always @(negedge i_clk) begin
        if (!i_rst_n || (start && !req_taken)) begin
            // Hold the current request, or stay idle during reset.
        end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start <= 1'b0;
        end else if (pending_reqs.size() > 0 &&
                     (!pending_reqs[0].hold_until_drained ||
                      (expected_rot.size() == 0 && !start))) begin
            i_req <= pending_reqs[0].req;
            start <= 1'b1;
            pending_reqs.pop_front();
            if (issued % 40 == 0)
                gap_style = $urandom_range(0, 2);
            issued++;
            case (gap_style)
                0: gap_left <= 0;
                1: gap_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60)
                                                            : $urandom_range(0, 3);
                default: gap_left <= ($urandom_range(0, 1) == 0) ? 0
                                                                 : $urandom_range(1, 8);
            endcase
        end else begin
            start <= 1'b0;
            if (pending_reqs.size() == 0)
                stimulus_done = 1'b1;
        end
    end

    // Monitor: predict each taken request and check each result strobe.
    always @(posedge i_clk) begin
        t_res want;
        req_taken = i_rst_n && start && !busy;
        if (req_taken)
            expected_rot.push_back(rotate_point(i_req));
        if (i_rst_n && o_done) begin
            if (expected_rot.size() == 0) begin
                $display("%0t: unexpected result x=%h y=%h z=%h sat=%b", $time,
                         o_res.out_x, o_res.out_y, o_res.out_z, o_res.saturated);
                error_count++;
            end else begin
                want = expected_rot.pop_front();
                if (o_res.out_x !== want.out_x) begin
                    $display("%0t: out_x expected %h actual %h", $time,
                             want.out_x, o_res.out_x);
                    error_count++;
                end
                if (o_res.out_y !== want.out_y) begin
                    $display("%0t: out_y expected %h actual %h", $time,
                             want.out_y, o_res.out_y);
                    error_count++;
                end
                if (o_res.out_z !== want.out_z) begin
                    $display("%0t: out_z expected %h actual %h", $time,
                             want.out_z, o_res.out_z);
                    error_count++;
                end
                if (o_res.saturated !== want.saturated) begin
                    $display("%0t: saturated expected %b actual %b", $time,
                             want.saturated, o_res.saturated);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: ends the run when neither a request nor a result has moved
    // for far longer than the pipeline latency plus the longest idle gap.
    // It looks at the handshake itself so it never depends on the monitor.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

endmodule
